>>> hdl/lwpf_pkg.sv
// ----------------------------------------------------------------------------
// lwpf_pkg
// Shared types and constants of the LCD window pixel framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lwpf_pkg;

  localparam int unsigned MaxSideDefault = 320;

  localparam int unsigned CfgW   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CountW = 18;
  localparam int unsigned PosW   = 4;

  typedef enum logic [1:0] {
    MODE_ORIENT = 2'd0,
    MODE_FRAME  = 2'd1,
    MODE_PIXEL  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PANEL_WIDTH  = 3'd0,
    CFG_PANEL_HEIGHT = 3'd1,
    CFG_COLUMN_OFS   = 3'd2,
    CFG_ROW_OFS      = 3'd3,
    CFG_ROTATION     = 3'd4,
    CFG_BLUE_FIRST   = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] Rot0   = 2'd0;
  localparam logic [1:0] Rot90  = 2'd1;
  localparam logic [1:0] Rot180 = 2'd2;
  localparam logic [1:0] Rot270 = 2'd3;

  localparam logic [7:0] CmdColumn   = 8'h2A;
  localparam logic [7:0] CmdRow      = 8'h2B;
  localparam logic [7:0] CmdMemWrite = 8'h2C;
  localparam logic [7:0] CmdAddrMode = 8'h36;

  localparam logic [7:0] AmBgr = 8'h08;
  localparam logic [7:0] AmMv  = 8'h20;
  localparam logic [7:0] AmMx  = 8'h40;
  localparam logic [7:0] AmMy  = 8'h80;

  localparam logic [CfgW-1:0] ResetWidth  = 9'd135;
  localparam logic [CfgW-1:0] ResetHeight = 9'd240;

  typedef struct packed {
    logic [15:0]       col_first;
    logic [15:0]       col_end;
    logic [15:0]       row_first;
    logic [15:0]       row_end;
    logic [CountW-1:0] count;
  } window_t;

  typedef struct packed {
    logic       dc_level;
    logic [7:0] out_byte;
    logic       last;
    logic       frame_done;
  } result_t;

  typedef struct packed {
    logic has_result;
    logic final_step;
  } step_t;

  typedef struct packed {
    logic              open;
    logic [CountW-1:0] remaining;
  } frame_t;

endpackage

`default_nettype wire

>>> hdl/lcd_window_pixel_framer.sv
// ----------------------------------------------------------------------------
// lcd_window_pixel_framer
// Turns orientation, begin-frame and pixel requests into tagged LCD bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata            tuser (low bit up)        tlast
//  s_axis    in   pixel_byte[7:0]  mode[1:0]                 -
//  m_axis    out  out_byte[7:0]    dc_level, frame_done      last
//  cfg       in   cfg_wdata_i = register value, cfg_idx_i = register index
//
// A pixel request in an open frame emits one byte, an orientation request
// two and a begin-frame request eleven: the request register emits one
// byte per cycle into the output register while m_axis does not stall.
// Reset restores the default panel settings and closes the frame.
// A stall on m_axis holds the output register; one request still enters.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_window_pixel_framer #(
  parameter int unsigned MAX_SIDE = lwpf_pkg::MaxSideDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,  // pixel_byte
  input  wire logic [1:0]                   s_axis_tuser_i,  // mode
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // out_byte
  output logic [1:0]                        m_axis_tuser_o,  // dc_level, frame_done
  output logic                              m_axis_tlast_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [lwpf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lwpf_pkg::CfgW-1:0]    cfg_wdata_i
);

  logic [lwpf_pkg::CfgW-1:0] width_q, height_q, col_ofs_q, row_ofs_q;
  logic [1:0]                rotation_q;
  logic                      blue_first_q;

  logic                      req_valid_q, req_valid_d;
  lwpf_pkg::mode_e           req_mode_q;
  logic [7:0]                req_pixel_q;
  logic [lwpf_pkg::PosW-1:0] pos_q, pos_d;

  lwpf_pkg::frame_t          frame_q, frame_d;
  lwpf_pkg::window_t         window;
  lwpf_pkg::result_t         result, out_q;
  lwpf_pkg::step_t           step_info;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free, step, retire, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= lwpf_pkg::ResetWidth;
      height_q     <= lwpf_pkg::ResetHeight;
      col_ofs_q    <= '0;
      row_ofs_q    <= '0;
      rotation_q   <= lwpf_pkg::Rot0;
      blue_first_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lwpf_pkg::CFG_PANEL_WIDTH:  width_q      <= cfg_wdata_i;
        lwpf_pkg::CFG_PANEL_HEIGHT: height_q     <= cfg_wdata_i;
        lwpf_pkg::CFG_COLUMN_OFS:   col_ofs_q    <= cfg_wdata_i;
        lwpf_pkg::CFG_ROW_OFS:      row_ofs_q    <= cfg_wdata_i;
        lwpf_pkg::CFG_ROTATION:     rotation_q   <= cfg_wdata_i[1:0];
        lwpf_pkg::CFG_BLUE_FIRST:   blue_first_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  lwpf_window #(
    .MAX_SIDE(MAX_SIDE)
  ) u_window (
    .panel_width_i (width_q),
    .panel_height_i(height_q),
    .column_ofs_i  (col_ofs_q),
    .row_ofs_i     (row_ofs_q),
    .rotation_i    (rotation_q),
    .window_o      (window)
  );

  lwpf_byte_sel u_byte_sel (
    .mode_i      (req_mode_q),
    .pixel_i     (req_pixel_q),
    .pos_i       (pos_q),
    .rotation_i  (rotation_q),
    .blue_first_i(blue_first_q),
    .window_i    (window),
    .frame_i     (frame_q),
    .result_o    (result),
    .step_o      (step_info)
  );

  always_comb begin
    out_free        = !out_valid_q || m_axis_tready_i;
    step            = req_valid_q && (!step_info.has_result || out_free);
    retire          = step && step_info.final_step;
    s_axis_tready_o = !req_valid_q || retire;
    accept          = s_axis_tvalid_i && s_axis_tready_o;

    req_valid_d = accept ? 1'b1 : (retire ? 1'b0 : req_valid_q);

    pos_d = pos_q;
    if (retire) begin
      pos_d = '0;
    end else if (step) begin
      pos_d = pos_q + lwpf_pkg::PosW'(1);
    end

    out_valid_d = out_valid_q;
    if (step && step_info.has_result) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    // Frame bookkeeping happens when a request retires.
    frame_d = frame_q;
    if (retire) begin
      priority if (req_mode_q == lwpf_pkg::MODE_FRAME) begin
        frame_d.remaining = window.count;
        frame_d.open      = (window.count != '0);
      end else if (req_mode_q == lwpf_pkg::MODE_PIXEL) begin
        if (frame_q.open && (frame_q.remaining != '0)) begin
          frame_d.remaining = frame_q.remaining - lwpf_pkg::CountW'(1);
          frame_d.open      = (frame_q.remaining != lwpf_pkg::CountW'(1));
        end else begin
          frame_d = '0;
        end
      end else begin
        frame_d = frame_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      frame_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      frame_q     <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_mode_q  <= lwpf_pkg::mode_e'(s_axis_tuser_i);
      req_pixel_q <= s_axis_tdata_i;
    end
    if (step && step_info.has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.out_byte;
  assign m_axis_tuser_o  = {out_q.frame_done, out_q.dc_level};
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire

>>> hdl/lwpf_window.sv
// ----------------------------------------------------------------------------
// lwpf_window
// Logical window geometry and frame byte count from the panel settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpf_window #(
  parameter int unsigned MAX_SIDE = lwpf_pkg::MaxSideDefault
) (
  input  wire logic [lwpf_pkg::CfgW-1:0] panel_width_i,
  input  wire logic [lwpf_pkg::CfgW-1:0] panel_height_i,
  input  wire logic [lwpf_pkg::CfgW-1:0] column_ofs_i,
  input  wire logic [lwpf_pkg::CfgW-1:0] row_ofs_i,
  input  wire logic [1:0]                rotation_i,
  output lwpf_pkg::window_t              window_o
);

  logic                        swap;
  logic [lwpf_pkg::CfgW-1:0]   w_raw, h_raw, w_side, h_side, co, ro;
  logic [2*lwpf_pkg::CfgW-1:0] area;
  logic [2*lwpf_pkg::CfgW:0]   bytes;

  always_comb begin
    swap  = (rotation_i == lwpf_pkg::Rot90) || (rotation_i == lwpf_pkg::Rot270);
    w_raw = swap ? panel_height_i : panel_width_i;
    h_raw = swap ? panel_width_i  : panel_height_i;
    co    = swap ? row_ofs_i      : column_ofs_i;
    ro    = swap ? column_ofs_i   : row_ofs_i;

    // A clamp can only bite when MAX_SIDE is below the register range.
    w_side = (32'(w_raw) > MAX_SIDE) ? lwpf_pkg::CfgW'(MAX_SIDE) : w_raw;
    h_side = (32'(h_raw) > MAX_SIDE) ? lwpf_pkg::CfgW'(MAX_SIDE) : h_raw;

    area  = w_side * h_side;
    bytes = {area, 1'b0};

    window_o.col_first = 16'(co);
    window_o.col_end   = 16'(co) + 16'(w_side) - 16'd1;
    window_o.row_first = 16'(ro);
    window_o.row_end   = 16'(ro) + 16'(h_side) - 16'd1;
    window_o.count     = (bytes[2*lwpf_pkg::CfgW:lwpf_pkg::CountW] != '0)
                         ? '1 : bytes[lwpf_pkg::CountW-1:0];
  end

endmodule

`default_nettype wire

>>> hdl/lwpf_byte_sel.sv
// ----------------------------------------------------------------------------
// lwpf_byte_sel
// Picks the output byte for the current request and byte position.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpf_byte_sel (
  input  wire lwpf_pkg::mode_e           mode_i,
  input  wire logic [7:0]                pixel_i,
  input  wire logic [lwpf_pkg::PosW-1:0] pos_i,
  input  wire logic [1:0]                rotation_i,
  input  wire logic                      blue_first_i,
  input  wire lwpf_pkg::window_t         window_i,
  input  wire lwpf_pkg::frame_t          frame_i,
  output lwpf_pkg::result_t              result_o,
  output lwpf_pkg::step_t                step_o
);

  localparam logic [lwpf_pkg::PosW-1:0] PosColCmd = 4'd0;
  localparam logic [lwpf_pkg::PosW-1:0] PosCsHi   = 4'd1;
  localparam logic [lwpf_pkg::PosW-1:0] PosCsLo   = 4'd2;
  localparam logic [lwpf_pkg::PosW-1:0] PosCeHi   = 4'd3;
  localparam logic [lwpf_pkg::PosW-1:0] PosCeLo   = 4'd4;
  localparam logic [lwpf_pkg::PosW-1:0] PosRowCmd = 4'd5;
  localparam logic [lwpf_pkg::PosW-1:0] PosRsHi   = 4'd6;
  localparam logic [lwpf_pkg::PosW-1:0] PosRsLo   = 4'd7;
  localparam logic [lwpf_pkg::PosW-1:0] PosReHi   = 4'd8;
  localparam logic [lwpf_pkg::PosW-1:0] PosReLo   = 4'd9;
  localparam logic [lwpf_pkg::PosW-1:0] PosMemCmd = 4'd10;
  localparam logic [lwpf_pkg::PosW-1:0] PosAmData = 4'd1;

  logic [7:0] am;

  always_comb begin
    unique case (rotation_i)
      lwpf_pkg::Rot90:  am = lwpf_pkg::AmMv | lwpf_pkg::AmMy;
      lwpf_pkg::Rot180: am = lwpf_pkg::AmMx | lwpf_pkg::AmMy;
      lwpf_pkg::Rot270: am = lwpf_pkg::AmMv | lwpf_pkg::AmMx;
      default:          am = 8'h00;
    endcase
    if (blue_first_i) begin
      am = am | lwpf_pkg::AmBgr;
    end

    result_o   = '0;
    step_o     = '0;
    unique case (mode_i)
      lwpf_pkg::MODE_ORIENT: begin
        step_o.has_result = 1'b1;
        if (pos_i == PosAmData) begin
          result_o.dc_level = 1'b1;
          result_o.out_byte = am;
          result_o.last     = 1'b1;
          step_o.final_step = 1'b1;
        end else begin
          result_o.out_byte = lwpf_pkg::CmdAddrMode;
        end
      end
      lwpf_pkg::MODE_FRAME: begin
        step_o.has_result = 1'b1;
        result_o.dc_level = 1'b1;
        unique case (pos_i)
          PosColCmd: begin
            result_o.dc_level = 1'b0;
            result_o.out_byte = lwpf_pkg::CmdColumn;
          end
          PosCsHi: result_o.out_byte = window_i.col_first[15:8];
          PosCsLo: result_o.out_byte = window_i.col_first[7:0];
          PosCeHi: result_o.out_byte = window_i.col_end[15:8];
          PosCeLo: result_o.out_byte = window_i.col_end[7:0];
          PosRowCmd: begin
            result_o.dc_level = 1'b0;
            result_o.out_byte = lwpf_pkg::CmdRow;
          end
          PosRsHi: result_o.out_byte = window_i.row_first[15:8];
          PosRsLo: result_o.out_byte = window_i.row_first[7:0];
          PosReHi: result_o.out_byte = window_i.row_end[15:8];
          PosReLo: result_o.out_byte = window_i.row_end[7:0];
          default: begin
            // Memory-write command closes the header.
            result_o.dc_level = 1'b0;
            result_o.out_byte = lwpf_pkg::CmdMemWrite;
            result_o.last     = 1'b1;
            step_o.final_step = 1'b1;
          end
        endcase
        if (pos_i > PosMemCmd) begin
          step_o.final_step = 1'b1;
        end
      end
      lwpf_pkg::MODE_PIXEL: begin
        step_o.final_step = 1'b1;
        if (frame_i.open && (frame_i.remaining != '0)) begin
          step_o.has_result   = 1'b1;
          result_o.dc_level   = 1'b1;
          result_o.out_byte   = pixel_i;
          result_o.last       = 1'b1;
          result_o.frame_done = (frame_i.remaining == lwpf_pkg::CountW'(1));
        end
      end
      default: begin
        step_o.final_step = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> tb/sv/lcd_window_pixel_framer_tb.sv
// ----------------------------------------------------------------------------
// lcd_window_pixel_framer_tb
// Self-checking testbench for the LCD window pixel framer. A behavioral
// model of the framer predicts every command and data byte. A monitor
// compares each m_axis transaction with the oldest prediction. Directed
// tests cover the special cases. Random frame traffic follows them, with
// idle cycles and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_window_pixel_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  ColSetCmd    = 8'h2A;
  localparam logic [7:0]  RowSetCmd    = 8'h2B;
  localparam logic [7:0]  RamWrCmd     = 8'h2C;
  localparam logic [7:0]  MadCtlCmd    = 8'h36;
  localparam logic [7:0]  MadBgr       = 8'h08;
  localparam logic [7:0]  MadMv        = 8'h20;
  localparam logic [7:0]  MadMx        = 8'h40;
  localparam logic [7:0]  MadMy        = 8'h80;
  localparam int unsigned SideLimit    = 320;
  localparam int unsigned ByteCountMax = 32'h3FFFF;
  // A begin-frame request keeps the block busy while it emits eleven header bytes.
  localparam int          SettleCycles = 16;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic       m_ready = 1'b0;
  logic       cfg_we = 1'b0;
  logic [lwpf_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [lwpf_pkg::CfgW-1:0]    cfg_data = '0;

  logic       s_ready;
  logic       m_valid;
  logic [7:0] m_data;
  logic [1:0] m_user;
  logic       m_last;

  lcd_window_pixel_framer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // pixel_byte
    .s_axis_tuser_i  (s_user),   // mode
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // out_byte
    .m_axis_tuser_o  (m_user),   // dc_level, frame_done
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the panel registers and the open frame.
  logic [8:0]  panel_w = 9'd135;
  logic [8:0]  panel_h = 9'd240;
  logic [8:0]  col_ofs = '0;
  logic [8:0]  row_ofs = '0;
  logic [1:0]  panel_rot = lwpf_pkg::Rot0;
  logic        panel_bgr = 1'b0;
  logic        frame_open = 1'b0;
  logic [17:0] frame_left = '0;

  lwpf_pkg::result_t lcd_bytes_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int requests_taken = 0;
  int answered_count = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int pixels_dropped = 0;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lwpf_pkg::result_t want;
    if (m_valid && m_ready) begin
      if (lcd_bytes_due.size() == 0) begin
        $error("out_byte: no byte expected, actual %02h", m_data);
        mismatches++;
      end else begin
        want = lcd_bytes_due.pop_front();
        bytes_checked++;
        if (m_user[0] !== want.dc_level) begin
          $error("dc_level: expected %0b, actual %0b", want.dc_level, m_user[0]);
          mismatches++;
        end
        if (m_data !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, m_data);
          mismatches++;
        end
        if (m_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_last);
          mismatches++;
        end
        if (m_user[1] !== want.frame_done) begin
          $error("frame_done: expected %0b, actual %0b", want.frame_done, m_user[1]);
          mismatches++;
        end
      end
    end
  end

  function automatic void expect_byte(logic dc, logic [7:0] b, logic lst, logic done);
    lwpf_pkg::result_t r;
    r.dc_level   = dc;
    r.out_byte   = b;
    r.last       = lst;
    r.frame_done = done;
    lcd_bytes_due.push_back(r);
  endfunction

  task automatic predict_lcd_bytes(lwpf_pkg::mode_e m, logic [7:0] pix);
    logic        swap;
    logic [7:0]  mad;
    int unsigned w, h, co, ro, ce, re, cnt;
    int          queued;
    queued = lcd_bytes_due.size();
    case (m)
      lwpf_pkg::MODE_ORIENT: begin
        mad = '0;
        case (panel_rot)
          lwpf_pkg::Rot90:  mad = MadMv | MadMy;
          lwpf_pkg::Rot180: mad = MadMx | MadMy;
          lwpf_pkg::Rot270: mad = MadMv | MadMx;
          default:          mad = '0;
        endcase
        if (panel_bgr) mad |= MadBgr;
        expect_byte(1'b0, MadCtlCmd, 1'b0, 1'b0);
        expect_byte(1'b1, mad, 1'b1, 1'b0);
      end
      lwpf_pkg::MODE_FRAME: begin
        swap = (panel_rot == lwpf_pkg::Rot90) || (panel_rot == lwpf_pkg::Rot270);
        w  = swap ? panel_h : panel_w;
        h  = swap ? panel_w : panel_h;
        co = swap ? row_ofs : col_ofs;
        ro = swap ? col_ofs : row_ofs;
        if (w > SideLimit) w = SideLimit;
        if (h > SideLimit) h = SideLimit;
        // A zero size wraps the end address to one below the offset.
        ce = (co + w - 1) & 32'hFFFF;
        re = (ro + h - 1) & 32'hFFFF;
        expect_byte(1'b0, ColSetCmd, 1'b0, 1'b0);
        expect_byte(1'b1, co[15:8], 1'b0, 1'b0);
        expect_byte(1'b1, co[7:0], 1'b0, 1'b0);
        expect_byte(1'b1, ce[15:8], 1'b0, 1'b0);
        expect_byte(1'b1, ce[7:0], 1'b0, 1'b0);
        expect_byte(1'b0, RowSetCmd, 1'b0, 1'b0);
        expect_byte(1'b1, ro[15:8], 1'b0, 1'b0);
        expect_byte(1'b1, ro[7:0], 1'b0, 1'b0);
        expect_byte(1'b1, re[15:8], 1'b0, 1'b0);
        expect_byte(1'b1, re[7:0], 1'b0, 1'b0);
        expect_byte(1'b0, RamWrCmd, 1'b1, 1'b0);
        cnt = 2 * w * h;
        if (cnt > ByteCountMax) cnt = ByteCountMax;
        frame_left = cnt[17:0];
        frame_open = (cnt != 0);
      end
      lwpf_pkg::MODE_PIXEL: begin
        if (!frame_open || frame_left == 0) begin
          frame_open = 1'b0;
          frame_left = '0;
          pixels_dropped++;
        end else begin
          frame_left = frame_left - 18'd1;
          if (frame_left == 0) begin
            frame_open = 1'b0;
            frames_closed++;
          end
          expect_byte(1'b1, pix, 1'b1, frame_left == 0);
        end
      end
      default: ;
    endcase
    if (lcd_bytes_due.size() > queued) answered_count++;
  endtask

  // Offers one request and returns at the edge that accepts it, tvalid still high.
  task automatic send_request(lwpf_pkg::mode_e m, logic [7:0] pix);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= m;
    s_data  <= pix;
    do @(posedge clk_i); while (!s_ready);
    requests_taken++;
    predict_lcd_bytes(m, pix);
  endtask

  task automatic send_pixels(int n);
    for (int i = 0; i < n; i++) begin
      send_request(lwpf_pkg::MODE_PIXEL, 8'($urandom_range(255)));
    end
  endtask

  task automatic wait_all_bytes();
    s_valid <= 1'b0;
    while (lcd_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(lwpf_pkg::cfg_idx_e idx, logic [8:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      lwpf_pkg::CFG_PANEL_WIDTH:  panel_w   = val;
      lwpf_pkg::CFG_PANEL_HEIGHT: panel_h   = val;
      lwpf_pkg::CFG_COLUMN_OFS:   col_ofs   = val;
      lwpf_pkg::CFG_ROW_OFS:      row_ofs   = val;
      lwpf_pkg::CFG_ROTATION:     panel_rot = val[1:0];
      lwpf_pkg::CFG_BLUE_FIRST:   panel_bgr = val[0];
      default: ;
    endcase
  endtask

  // Registers change only with the block idle, so the previous traffic drains first.
  task automatic set_panel(logic [8:0] w, logic [8:0] h, logic [8:0] co, logic [8:0] ro,
                           logic [1:0] rot, logic bgr);
    wait_all_bytes();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(lwpf_pkg::CFG_PANEL_WIDTH, w);
    write_reg(lwpf_pkg::CFG_PANEL_HEIGHT, h);
    write_reg(lwpf_pkg::CFG_COLUMN_OFS, co);
    write_reg(lwpf_pkg::CFG_ROW_OFS, ro);
    write_reg(lwpf_pkg::CFG_ROTATION, {7'd0, rot});
    write_reg(lwpf_pkg::CFG_BLUE_FIRST, {8'd0, bgr});
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_request(lwpf_pkg::MODE_ORIENT, 8'h00);
    send_request(lwpf_pkg::MODE_FRAME, 8'hFF);
    send_request(lwpf_pkg::MODE_PIXEL, 8'h00);
    send_request(lwpf_pkg::MODE_PIXEL, 8'hFF);
    send_request(lwpf_pkg::MODE_PIXEL, 8'h5A);
  endtask

  task automatic test_orientations();
    for (int r = 0; r < 4; r++) begin
      set_panel(9'd135, 9'd240, 9'd0, 9'd0, 2'(r), (r == 0) || (r == 2));
      send_request(lwpf_pkg::MODE_ORIENT, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_window_extremes();
    // Oversized sides are clamped, and the swap at ninety degrees applies.
    set_panel(9'd511, 9'd511, 9'd511, 9'd511, lwpf_pkg::Rot90, 1'b1);
    send_request(lwpf_pkg::MODE_FRAME, 8'h00);
    // A zero width still sends the window but opens no frame.
    set_panel(9'd0, 9'd7, 9'd0, 9'd5, lwpf_pkg::Rot0, 1'b0);
    send_request(lwpf_pkg::MODE_FRAME, 8'h00);
    send_request(lwpf_pkg::MODE_PIXEL, 8'hA5);
    set_panel(9'd1, 9'd1, 9'd0, 9'd319, lwpf_pkg::Rot270, 1'b0);
    send_request(lwpf_pkg::MODE_FRAME, 8'h00);
    send_pixels(2);
    send_request(lwpf_pkg::MODE_PIXEL, 8'h3C);
    send_request(lwpf_pkg::MODE_NONE, 8'hFF);
  endtask

  task automatic test_begin_while_open();
    set_panel(9'd1, 9'd2, 9'd3, 9'd4, lwpf_pkg::Rot180, 1'b1);
    send_request(lwpf_pkg::MODE_FRAME, 8'h00);
    send_pixels(2);
    send_request(lwpf_pkg::MODE_FRAME, 8'h00);
    send_pixels(4);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    set_panel(9'd4, 9'd4, 9'd10, 9'd20, lwpf_pkg::Rot0, 1'b0);
    // The receiver holds off while a frame header and twelve pixels are offered.
    hold_left = 80;
    send_request(lwpf_pkg::MODE_FRAME, 8'h00);
    send_pixels(12);
    // The sender stops until every queued byte has been taken.
    wait_all_bytes();
    send_pixels(20);
  endtask

  task automatic test_random_frames(int send_pct, int recv_pct, int quota);
    int first_count, pick, n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_count = answered_count;
    while (answered_count - first_count < quota) begin
      if ($urandom_range(1) == 0) begin
        pick = $urandom_range(19);
        set_panel((pick == 0) ? 9'd0 : (pick == 1) ? 9'($urandom_range(5, 511))
                                                    : 9'($urandom_range(1, 4)),
                  ($urandom_range(19) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(1, 4)),
                  9'($urandom_range(511)), 9'($urandom_range(511)),
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Noise: requests of any kind, stray pixels among them.
        repeat ($urandom_range(1, 4))
          send_request(lwpf_pkg::mode_e'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        if (pick < 30) send_request(lwpf_pkg::MODE_ORIENT, 8'($urandom_range(255)));
        send_request(lwpf_pkg::MODE_FRAME, 8'($urandom_range(255)));
        n = frame_left;
        if (n > 40) begin
          n = $urandom_range(0, 6);
        end else begin
          pick = $urandom_range(9);
          if (pick == 0 && n > 0) n = $urandom_range(0, n - 1);
          else if (pick == 1) n = n + $urandom_range(1, 3);
        end
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(19) == 0)
            send_request($urandom_range(1) ? lwpf_pkg::MODE_ORIENT : lwpf_pkg::MODE_NONE,
                         8'($urandom_range(255)));
          send_request(lwpf_pkg::MODE_PIXEL, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 28;
    recv_idle_pct = 47;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_orientations();
    test_window_extremes();
    test_begin_while_open();
    test_backpressure();
    test_random_frames(28, 47, 25);
    test_random_frames(47, 28, 25);
    test_random_frames(0, 0, 25);

    wait_all_bytes();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d requests (%0d answered), checked %0d LCD bytes.",
             requests_taken, answered_count, bytes_checked);
    $display("Closed %0d frames, dropped %0d stray pixels, %0d mismatches.",
             frames_closed, pixels_dropped, mismatches);
    if (mismatches == 0 && lcd_bytes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
